/* sv/crcfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants, result codes and CRC helpers for the CRC framed packet
// resync receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int CHECK_BYTES  = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

  // Result codes on event_res
  localparam logic [1:0] EV_FILL    = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_SHIFT   = 2'd2;
  localparam logic [1:0] EV_CLEARED = 2'd3;

  // Input action codes
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT_MAX) ? v : v + 32'd1;
  endfunction

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* sv/crc_framed_packet_resync_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_framed_packet_resync_receiver
// Gathers received bytes into a one-frame window, checks CRC-16/CCITT-FALSE
// and either accepts the frame or slides the window by one byte.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one item per received byte or a
// clear action. Output channel (out_valid/out_stall) returns one result item
// per input item: the event, the accepted frame's sequence and time fields,
// and the saturating statistics after that item.
// Timing: a byte that does not complete the window, and a clear, give their
// result in the cycle after acceptance. A byte that completes the window
// starts a CRC check: the window is read back one byte per cycle through
// the single read port of the window memory, each byte but the two check
// bytes folded into the CRC by one shared byte unit.
// Throughput: one item per cycle while filling and the output is not
// stalled; no new item is taken while a CRC check runs. The window is a
// circular buffer, so a mismatch slides it by moving the head pointer only.
// Reset clears all counters, empties the window and marks that no frame has
// been accepted yet. When the output stalls, the result holds in the output
// register and the input stalls until that result is taken.
// ----------------------------------------------------------------------------
module crc_framed_packet_resync_receiver #(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic        seq_gap,
  output logic [31:0] frame_seq,
  output logic [31:0] frame_time,
  output logic [31:0] good_frames,
  output logic [31:0] crc_failures,
  output logic [31:0] gap_count,
  output logic [31:0] byte_total,
  output logic [31:0] latest_seq
);

  localparam int FRAME_BYTES = crcfr_pkg::HEADER_BYTES + PAYLOAD_BYTES +
                               crcfr_pkg::CHECK_BYTES;
  localparam int IW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  localparam logic [CW-1:0] FRAME_LEN = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] LAST_FILL = CW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] CRC_END   = CW'(FRAME_BYTES - 2);
  localparam logic [CW-1:0] SEQ_END   = CW'(4);
  localparam logic [CW-1:0] TIME_END  = CW'(8);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);
  localparam logic [IW-1:0] HEAD_LAST = IW'(FRAME_BYTES - 1);
  localparam logic [CW:0]   WRAP      = (CW + 1)'(FRAME_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state;
  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rd_data;
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [CW:0]   rd_sum;
  logic [CW:0]   wr_sum;
  logic [CW-1:0] fill_level;
  logic [CW-1:0] cnt;
  logic [15:0]   crc;
  logic [15:0]   rx_word;
  logic [31:0]   seq_word;
  logic [31:0]   time_word;
  logic [31:0]   accepted_count;
  logic [31:0]   mismatch_count;
  logic [31:0]   gap_total;
  logic [31:0]   bytes_seen;
  logic [31:0]   previous_seq;
  logic          awaiting_first;

  logic          out_free;
  logic          out_load;
  logic          accept;
  logic          wr_en;
  logic          gap_hit;
  logic          crc_match;
  logic [31:0]   accepted_next;
  logic [31:0]   mismatch_next;
  logic [31:0]   gap_next;
  logic [31:0]   bytes_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (action == crcfr_pkg::ACT_DATA);

  // A new result enters the output register at this edge
  assign out_load = (state == S_IDLE && accept &&
                     (action == crcfr_pkg::ACT_CLEAR || fill_level != LAST_FILL)) ||
                    (state == S_DONE && out_free);

  // Circular window addressing relative to the head pointer
  assign rd_sum  = (CW + 1)'(cnt) + (CW + 1)'(head);
  assign rd_addr = (rd_sum >= WRAP) ? IW'(rd_sum - WRAP) : IW'(rd_sum);
  assign wr_sum  = (CW + 1)'(fill_level) + (CW + 1)'(head);
  assign wr_addr = (wr_sum >= WRAP) ? IW'(wr_sum - WRAP) : IW'(wr_sum);
  assign head_next = (head == HEAD_LAST) ? '0 : head + IW'(1);

  assign accepted_next = crcfr_pkg::sat_inc(accepted_count);
  assign mismatch_next = crcfr_pkg::sat_inc(mismatch_count);
  assign gap_next      = crcfr_pkg::sat_inc(gap_total);
  assign bytes_next    = crcfr_pkg::sat_inc(bytes_seen);
  assign gap_hit       = !awaiting_first && (seq_word != previous_seq + 32'd1);
  assign crc_match     = (rx_word == crc);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= data_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      head           <= '0;
      fill_level     <= '0;
      cnt            <= '0;
      accepted_count <= '0;
      mismatch_count <= '0;
      gap_total      <= '0;
      bytes_seen     <= '0;
      previous_seq   <= '0;
      awaiting_first <= 1'b1;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == crcfr_pkg::ACT_CLEAR) begin
              head           <= '0;
              fill_level     <= '0;
              accepted_count <= '0;
              mismatch_count <= '0;
              gap_total      <= '0;
              bytes_seen     <= '0;
              previous_seq   <= '0;
              awaiting_first <= 1'b1;
              out_valid      <= 1'b1;
              event_res      <= crcfr_pkg::EV_CLEARED;
              seq_gap        <= 1'b0;
              frame_seq      <= '0;
              frame_time     <= '0;
              good_frames    <= '0;
              crc_failures   <= '0;
              gap_count      <= '0;
              byte_total     <= '0;
              latest_seq     <= '0;
            end else begin
              bytes_seen <= bytes_next;
              fill_level <= fill_level + CW'(1);
              if (fill_level == LAST_FILL) begin
                // window full: run the check
                state <= S_CALC;
                cnt   <= '0;
                crc   <= crcfr_pkg::CRC_INIT;
              end else begin
                out_valid    <= 1'b1;
                event_res    <= crcfr_pkg::EV_FILL;
                seq_gap      <= 1'b0;
                frame_seq    <= '0;
                frame_time   <= '0;
                good_frames  <= accepted_count;
                crc_failures <= mismatch_count;
                gap_count    <= gap_total;
                byte_total   <= bytes_next;
                latest_seq   <= previous_seq;
              end
            end
          end
        end
        S_CALC: begin
          cnt <= (cnt == FRAME_LEN) ? '0 : cnt + CW'(1);
          // rd_data holds window byte cnt-1
          if (cnt >= CNT_ONE && cnt <= CRC_END) begin
            crc <= crcfr_pkg::crc_byte(crc, rd_data);
          end
          if (cnt >= CNT_ONE && cnt <= SEQ_END) begin
            seq_word <= {rd_data, seq_word[31:8]};
          end
          if (cnt > SEQ_END && cnt <= TIME_END) begin
            time_word <= {rd_data, time_word[31:8]};
          end
          if (cnt >= LAST_FILL) begin
            rx_word <= {rd_data, rx_word[15:8]};
          end
          if (cnt == FRAME_LEN) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            byte_total <= bytes_seen;
            if (crc_match) begin
              fill_level     <= '0;
              accepted_count <= accepted_next;
              previous_seq   <= seq_word;
              awaiting_first <= 1'b0;
              if (gap_hit) begin
                gap_total <= gap_next;
              end
              event_res    <= crcfr_pkg::EV_ACCEPT;
              seq_gap      <= gap_hit;
              frame_seq    <= seq_word;
              frame_time   <= time_word;
              good_frames  <= accepted_next;
              crc_failures <= mismatch_count;
              gap_count    <= gap_hit ? gap_next : gap_total;
              latest_seq   <= seq_word;
            end else begin
              // drop the oldest byte
              head           <= head_next;
              fill_level     <= LAST_FILL;
              mismatch_count <= mismatch_next;
              event_res      <= crcfr_pkg::EV_SHIFT;
              seq_gap        <= 1'b0;
              frame_seq      <= '0;
              frame_time     <= '0;
              good_frames    <= accepted_count;
              crc_failures   <= mismatch_next;
              gap_count      <= gap_total;
              latest_seq     <= previous_seq;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> fill_level < FRAME_LEN)
    else $error("window fill level reached a full frame while idle");

  a_gap_le_good: assert property (@(posedge clk) disable iff (rst)
    gap_total <= accepted_count)
    else $error("more sequence gaps than accepted frames");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == crcfr_pkg::EV_ACCEPT |-> latest_seq == frame_seq)
    else $error("accepted frame sequence not recorded as latest");

  a_non_accept_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != crcfr_pkg::EV_ACCEPT |->
      !seq_gap && frame_seq == '0 && frame_time == '0)
    else $error("frame fields set on a result that accepted no frame");

  a_calc_stalls: assert property (@(posedge clk) disable iff (rst)
    $past(state) == S_CALC && state == S_DONE |-> $past(cnt) == FRAME_LEN)
    else $error("check finished before the whole window was read");

endmodule
